@@ rtl/bnpr_pkg.sv @@
// Shared types, constants and register codes for the batch-norm/PReLU int8 requantizer.
`default_nettype none
package bnpr_pkg;

    localparam int MAX_CHANNELS_DEF = 512;

    localparam int CH_W       = 10;   // channel counter, covers channels_in_use range
    localparam int PIX_W      = 16;
    localparam int PPC_W      = 17;
    localparam int CIU_W      = 10;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam int TBL_W      = 80;   // {scale, offset, slope}

    localparam logic [CFG_IDX_W-1:0] CFG_INV_OUT_SCALE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXELS_PER_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS_IN_USE    = 2'd2;

    localparam logic [31:0]    INV_OUT_SCALE_RST = 32'd65536;
    localparam logic [PPC_W-1:0] PPC_RST         = 17'd1;
    localparam logic [PPC_W-1:0] PPC_MAX         = 17'd65536;
    localparam logic [CIU_W-1:0] CIU_RST         = 10'd512;

    localparam logic            KIND_LOAD = 1'b0;
    localparam logic            KIND_DATA = 1'b1;
    localparam logic [15:0]     SLOPE_ONE = 16'd4096;   // unity in Q4.12
    localparam logic signed [7:0] Q_MAX   = 8'sd127;
    localparam logic signed [7:0] Q_MIN   = -8'sd128;

    typedef struct packed {
        logic               kind;
        logic [8:0]         load_channel;
        logic signed [31:0] acc;
        logic [31:0]        conv_scale_in;
        logic signed [31:0] bn_scale_in;
        logic signed [31:0] bn_offset_in;
        logic signed [15:0] slope_in;
    } t_in;

    typedef struct packed {
        logic signed [7:0] quantized;
        logic [8:0]        channel_out;
        logic              last;
    } t_out;

    typedef enum logic [1:0] {
        MUL_LOAD,
        MUL_ACC,
        MUL_LIMB
    } t_mul_sel;

    typedef struct packed {
        logic       capture;
        logic       rd_en;
        logic       mul_en;
        t_mul_sel   mul_sel;
        logic       x_en;
        logic       abs_en;
        logic       limb_en;
        logic [1:0] limb_idx;
        logic       pass;
        logic       tbl_wr;
        logic       out_wr;
    } t_dp_cmd;

    typedef struct packed {
        logic out_free;
    } t_dp_status;

endpackage
`default_nettype wire

@@ rtl/bn_prelu_int8_requantizer_top.sv @@
// Top level of the per-channel batch-norm/PReLU int8 requantizer.
// Data item: table read, scale multiply, offset add, magnitude, two limb-serial passes on the shared
// 33x33 multiplier, then the output step; no new item is taken until the sequencer is idle again.
// Load item: scale multiply, then round and table write, no result.
// A pending result in the output register stalls only the output step of the next data item.
// Synchronous active-low reset clears state, counters and config; coefficient RAM is not cleared.
`default_nettype none
module bn_prelu_int8_requantizer_top #(
    parameter int MAX_CHANNELS = bnpr_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_cfg_we,
    input  wire logic [bnpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [bnpr_pkg::CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_ready,
    input  wire bnpr_pkg::t_in                   i_in_data,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_ready,
    output bnpr_pkg::t_out                       o_out_data
);

    bnpr_pkg::t_dp_cmd    cmd;
    bnpr_pkg::t_dp_status status;

    bnpr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_kind  (i_in_data.kind),
        .o_in_ready (o_in_ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    bnpr_datapath #(
        .MAX_CHANNELS (MAX_CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // one item at a time: ready drops after every accept
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("second item accepted while one is in work");

    // a load item never raises a result
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.kind == bnpr_pkg::KIND_LOAD)
        |=> !$rose(o_out_valid) ##1 !$rose(o_out_valid))
        else $error("result raised by a load item");

    // a new result only appears out of the output step, never while idle
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without an item in work");

endmodule
`default_nettype wire

@@ rtl/bnpr_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module bnpr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/bnpr_ctrl.sv @@
// Sequencer: data items go via table read, multiplies, limb passes, output.
`default_nettype none
module bnpr_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_in_kind,
    output logic                      o_in_ready,
    input  wire bnpr_pkg::t_dp_status i_status,
    output bnpr_pkg::t_dp_cmd         o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD,
        S_MUL_X,
        S_ADD_X,
        S_ABS,
        S_LMUL,
        S_LADD,
        S_QUANT,
        S_LD_MUL,
        S_LD_WR
    } t_state;

    t_state     r_state;
    logic [1:0] r_idx;
    logic       r_pass;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= 2'd0;
            r_pass  <= 1'b0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= (i_in_kind == bnpr_pkg::KIND_DATA) ? S_RD : S_LD_MUL;
                    end
                end
                S_RD:    r_state <= S_MUL_X;
                S_MUL_X: r_state <= S_ADD_X;
                S_ADD_X: r_state <= S_ABS;
                S_ABS: begin
                    r_idx   <= 2'd0;
                    r_pass  <= 1'b0;
                    r_state <= S_LMUL;
                end
                S_LMUL:  r_state <= S_LADD;
                S_LADD: begin
                    if (r_idx == 2'd3) begin
                        if (r_pass) begin
                            r_state <= S_QUANT;
                        end else begin
                            r_pass  <= 1'b1;
                            r_idx   <= 2'd0;
                            r_state <= S_LMUL;
                        end
                    end else begin
                        r_idx   <= r_idx + 2'd1;
                        r_state <= S_LMUL;
                    end
                end
                S_QUANT: begin
                    if (i_status.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_LD_MUL: r_state <= S_LD_WR;
                S_LD_WR:  r_state <= S_IDLE;
                default:  r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        o_cmd          = '0;
        o_cmd.mul_sel  = bnpr_pkg::MUL_LIMB;
        o_cmd.limb_idx = r_idx;
        o_cmd.pass     = r_pass;
        case (r_state)
            S_IDLE:   o_cmd.capture = i_in_valid;
            S_RD:     o_cmd.rd_en   = 1'b1;
            S_MUL_X: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bnpr_pkg::MUL_ACC;
            end
            S_ADD_X:  o_cmd.x_en    = 1'b1;
            S_ABS:    o_cmd.abs_en  = 1'b1;
            S_LMUL:   o_cmd.mul_en  = 1'b1;
            S_LADD:   o_cmd.limb_en = 1'b1;
            S_QUANT:  o_cmd.out_wr  = i_status.out_free;
            S_LD_MUL: begin
                o_cmd.mul_en  = 1'b1;
                o_cmd.mul_sel = bnpr_pkg::MUL_LOAD;
            end
            S_LD_WR:  o_cmd.tbl_wr  = 1'b1;
            default:  o_cmd.capture = 1'b0;
        endcase
    end

    // the last limb add of the second pass always hands over to the output step
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_LADD && r_idx == 2'd3 && r_pass) |=> (r_state == S_QUANT))
        else $error("limb sequence did not end in output step");

    // a load item goes straight to the scale multiply
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_in_valid && i_in_kind == bnpr_pkg::KIND_LOAD)
        |=> (r_state == S_LD_MUL))
        else $error("load item did not start the scale multiply");

    // output step holds while the output register is still occupied
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_QUANT && !i_status.out_free) |=> (r_state == S_QUANT))
        else $error("output step left while result pending");

endmodule
`default_nettype wire

@@ rtl/bnpr_datapath.sv @@
// Datapath: config registers, coefficient RAM, shared multiplier, limb product, rounding.
`default_nettype none
module bnpr_datapath #(
    parameter int MAX_CHANNELS = bnpr_pkg::MAX_CHANNELS_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_cfg_we,
    input  wire logic [bnpr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [bnpr_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  wire bnpr_pkg::t_in                      i_in_data,
    input  wire bnpr_pkg::t_dp_cmd                  i_cmd,
    output bnpr_pkg::t_dp_status                    o_status,
    output logic                                    o_out_valid,
    input  wire logic                               i_out_ready,
    output bnpr_pkg::t_out                          o_out_data
);

    localparam int AW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CH_W = bnpr_pkg::CH_W;

    // configuration
    logic [31:0]                r_inv;
    logic [bnpr_pkg::PPC_W-1:0] r_ppc;
    logic [bnpr_pkg::CIU_W-1:0] r_ciu;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inv <= bnpr_pkg::INV_OUT_SCALE_RST;
            r_ppc <= bnpr_pkg::PPC_RST;
            r_ciu <= bnpr_pkg::CIU_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bnpr_pkg::CFG_INV_OUT_SCALE:      r_inv <= i_cfg_data;
                bnpr_pkg::CFG_PIXELS_PER_CHANNEL: r_ppc <= i_cfg_data[bnpr_pkg::PPC_W-1:0];
                bnpr_pkg::CFG_CHANNELS_IN_USE:    r_ciu <= i_cfg_data[bnpr_pkg::CIU_W-1:0];
                default:                          r_inv <= r_inv;
            endcase
        end
    end

    // item capture
    bnpr_pkg::t_in r_item;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_item <= i_in_data;
        end
    end

    // position counters
    logic [bnpr_pkg::PIX_W-1:0] r_pix;
    logic [CH_W-1:0]            r_ch;
    logic [bnpr_pkg::PPC_W-1:0] ppc_eff;
    logic [bnpr_pkg::CIU_W-1:0] ciu_eff;
    logic                       end_ch;
    logic                       end_t;

    always_comb begin
        if (r_ppc == '0) begin
            ppc_eff = bnpr_pkg::PPC_RST;
        end else if (r_ppc > bnpr_pkg::PPC_MAX) begin
            ppc_eff = bnpr_pkg::PPC_MAX;
        end else begin
            ppc_eff = r_ppc;
        end
        if (r_ciu == '0) begin
            ciu_eff = bnpr_pkg::CIU_W'(1);
        end else if (32'(r_ciu) > 32'(MAX_CHANNELS)) begin
            ciu_eff = bnpr_pkg::CIU_W'(MAX_CHANNELS);
        end else begin
            ciu_eff = r_ciu;
        end
        end_ch = ({1'b0, r_pix} + 17'd1) >= ppc_eff;
        end_t  = ({1'b0, r_ch} + 11'd1) >= {1'b0, ciu_eff};
    end

    // coefficient table
    logic [CH_W+AW-1:0]          ch_wide;
    logic [9+AW-1:0]             lc_wide;
    logic [AW-1:0]               raddr;
    logic [AW-1:0]               waddr;
    logic                        lc_ok;
    logic [bnpr_pkg::TBL_W-1:0]  tbl_rdata;
    logic [bnpr_pkg::TBL_W-1:0]  tbl_wdata;
    logic signed [31:0]          tbl_scale;
    logic signed [31:0]          tbl_offset;
    logic signed [15:0]          tbl_slope;

    assign ch_wide    = {{AW{1'b0}}, r_ch};
    assign lc_wide    = {{AW{1'b0}}, r_item.load_channel};
    assign raddr      = ch_wide[AW-1:0];
    assign waddr      = lc_wide[AW-1:0];
    assign lc_ok      = 32'(r_item.load_channel) < 32'(MAX_CHANNELS);
    assign tbl_scale  = tbl_rdata[79:48];
    assign tbl_offset = tbl_rdata[47:16];
    assign tbl_slope  = tbl_rdata[15:0];

    bnpr_ram #(
        .WIDTH (bnpr_pkg::TBL_W),
        .DEPTH (MAX_CHANNELS),
        .AW    (AW)
    ) u_tbl (
        .i_clk   (i_clk),
        .i_we    (i_cmd.tbl_wr && lc_ok),
        .i_waddr (waddr),
        .i_wdata (tbl_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (raddr),
        .o_rdata (tbl_rdata)
    );

    // shared multiplier
    logic [31:0]        r_limb [4];
    logic [31:0]        r_carry;
    logic [15:0]        r_fm;
    logic               r_neg;
    logic [63:0]        r_prod;
    logic [63:0]        r_x;
    logic signed [32:0] bs_ext;
    logic signed [32:0] bn_mag;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic signed [65:0] mul_p;
    logic [31:0]        limb_m;

    assign bs_ext = {r_item.bn_scale_in[31], r_item.bn_scale_in};
    assign bn_mag = r_item.bn_scale_in[31] ? (33'sd0 - bs_ext) : bs_ext;
    assign limb_m = i_cmd.pass ? r_inv : {16'd0, r_fm};

    always_comb begin
        case (i_cmd.mul_sel)
            bnpr_pkg::MUL_LOAD: begin
                mul_a = {1'b0, r_item.conv_scale_in};
                mul_b = bn_mag;
            end
            bnpr_pkg::MUL_ACC: begin
                mul_a = {r_item.acc[31], r_item.acc};
                mul_b = {tbl_scale[31], tbl_scale};
            end
            bnpr_pkg::MUL_LIMB: begin
                mul_a = {1'b0, r_limb[i_cmd.limb_idx]};
                mul_b = {1'b0, limb_m};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        mul_p = mul_a * mul_b;
    end

    // x, magnitude and slope selection
    logic        x_neg;
    logic [63:0] x_mag;
    logic [63:0] limb_sum;

    assign x_neg    = r_x[63];
    assign x_mag    = x_neg ? (64'd0 - r_x) : r_x;
    assign limb_sum = r_prod + {32'd0, (i_cmd.limb_idx == 2'd0) ? 32'd0 : r_carry};

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul_en) begin
            r_prod <= mul_p[63:0];
        end
        if (i_cmd.x_en) begin
            r_x <= r_prod + {{24{tbl_offset[31]}}, tbl_offset, 8'h00};
        end
        if (i_cmd.abs_en) begin
            r_limb[0] <= x_mag[31:0];
            r_limb[1] <= x_mag[63:32];
            r_limb[2] <= 32'd0;
            r_limb[3] <= 32'd0;
            if (x_neg) begin
                // negative slope flips the sign back to positive
                r_neg <= !tbl_slope[15];
                r_fm  <= tbl_slope[15] ? (16'd0 - tbl_slope) : tbl_slope;
            end else begin
                r_neg <= 1'b0;
                r_fm  <= bnpr_pkg::SLOPE_ONE;
            end
        end
        if (i_cmd.limb_en) begin
            r_limb[i_cmd.limb_idx] <= limb_sum[31:0];
            r_carry                <= limb_sum[63:32];
        end
    end

    // combined scale on load: Q16.48 product rounded half to even to Q8.24
    logic [39:0] ld_ip;
    logic [23:0] ld_rem;
    logic        ld_up;
    logic [40:0] ld_ipr;
    logic [31:0] ld_scale;

    always_comb begin
        ld_ip  = r_prod[63:24];
        ld_rem = r_prod[23:0];
        ld_up  = ld_rem[23] && ((|ld_rem[22:0]) || ld_ip[0]);
        ld_ipr = {1'b0, ld_ip} + {40'd0, ld_up};
        if (r_item.bn_scale_in[31]) begin
            if (ld_ipr > 41'h0_8000_0000) begin
                ld_scale = 32'h8000_0000;
            end else begin
                ld_scale = 32'd0 - ld_ipr[31:0];
            end
        end else begin
            if (ld_ipr > 41'h0_7FFF_FFFF) begin
                ld_scale = 32'h7FFF_FFFF;
            end else begin
                ld_scale = ld_ipr[31:0];
            end
        end
        tbl_wdata = {ld_scale, r_item.bn_offset_in, r_item.slope_in};
    end

    // output rounding: 52 fraction bits, half to even, saturate to int8
    logic               q_big;
    logic [31:0]        q_ip;
    logic [51:0]        q_frac;
    logic               q_up;
    logic [32:0]        q_ipr;
    logic signed [7:0]  q_val;

    always_comb begin
        q_big  = (r_limb[3] != 32'd0) || (r_limb[2][31:20] != 12'd0);
        q_ip   = {r_limb[2][19:0], r_limb[1][31:20]};
        q_frac = {r_limb[1][19:0], r_limb[0]};
        q_up   = q_frac[51] && ((|q_frac[50:0]) || q_ip[0]);
        q_ipr  = {1'b0, q_ip} + {32'd0, q_up};
        if (q_big) begin
            q_val = r_neg ? bnpr_pkg::Q_MIN : bnpr_pkg::Q_MAX;
        end else if (r_neg) begin
            q_val = (q_ipr > 33'd128) ? bnpr_pkg::Q_MIN : (8'sd0 - q_ipr[7:0]);
        end else begin
            q_val = (q_ipr > 33'd127) ? bnpr_pkg::Q_MAX : q_ipr[7:0];
        end
    end

    // output register and counter advance
    bnpr_pkg::t_out r_out;
    logic           r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pix       <= '0;
            r_ch        <= '0;
        end else begin
            if (i_cmd.out_wr) begin
                r_out_valid <= 1'b1;
                if (end_ch) begin
                    r_pix <= '0;
                    r_ch  <= end_t ? '0 : (r_ch + CH_W'(1));
                end else begin
                    r_pix <= r_pix + bnpr_pkg::PIX_W'(1);
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_wr) begin
            r_out.quantized   <= q_val;
            r_out.channel_out <= r_ch[8:0];
            r_out.last        <= end_ch && end_t;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out;
    assign o_status.out_free = !r_out_valid || i_out_ready;

endmodule
`default_nettype wire

@@ tb/bn_prelu_int8_requantizer_top_tb.sv @@
// Self-checking testbench for the batch-norm/PReLU int8 requantizer, with its own bit-exact predictor.
`timescale 1ns / 1ps

module bn_prelu_int8_requantizer_top_tb;

    localparam int MAX_CH       = bnpr_pkg::MAX_CHANNELS_DEF;
    localparam int CYCLE_LIMIT  = 600_000;
    localparam int HOLD_CYCLES  = 400;
    localparam int LOAD_SETTLE  = 8;    // lets a load item finish; a load gives no result
    localparam int TAIL_CYCLES  = 30;

    localparam logic K_LOAD = bnpr_pkg::KIND_LOAD;
    localparam logic K_DATA = bnpr_pkg::KIND_DATA;

    logic                            i_clk;
    logic                            i_rst_n;
    logic                            i_cfg_we;
    logic [bnpr_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [bnpr_pkg::CFG_DATA_W-1:0] i_cfg_data;
    logic                            i_in_valid;
    logic                            o_in_ready;
    bnpr_pkg::t_in                   i_in_data;
    logic                            o_out_valid;
    logic                            i_out_ready;
    bnpr_pkg::t_out                  o_out_data;

    bn_prelu_int8_requantizer_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    // Predictor state: coefficient tables, position in the tensor, registers
    logic signed [31:0] coef_scale  [MAX_CH];
    logic signed [31:0] coef_offset [MAX_CH];
    logic signed [15:0] coef_slope  [MAX_CH];
    bit                 coef_loaded [MAX_CH];
    int unsigned        pix_cnt;
    int unsigned        chan_cnt;
    logic [31:0]        cfg_inv = bnpr_pkg::INV_OUT_SCALE_RST;
    int unsigned        cfg_ppc = bnpr_pkg::PPC_RST;
    int unsigned        cfg_ciu = bnpr_pkg::CIU_RST;

    bnpr_pkg::t_out due_results [$];
    int   n_errors;
    int   idle_rate;
    bit   hold_req;
    int   cycle_cnt;

    typedef struct packed {
        bnpr_pkg::t_in  item;
        logic           typed;
        bnpr_pkg::t_out want;
    } t_step_row;

    // Loads for channels 0..9, then one data item per channel (reset config: one pixel each).
    // Rounding ties, zero and negative slope, saturation both ways, load rounding tie.
    localparam t_step_row DIRECTED_STEPS [20] = '{
        {K_LOAD, 9'd0, 32'h0000_0000, 32'h0100_0000, 32'h0100_0000, 32'h0000_8000, 16'h1000,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_LOAD, 9'd1, 32'h0000_0000, 32'h0100_0000, 32'h0100_0000, 32'h0000_8000, 16'h1000,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_LOAD, 9'd2, 32'h0000_0000, 32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 16'h0000,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_LOAD, 9'd3, 32'h0000_0000, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'h8000,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_LOAD, 9'd4, 32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'h8000_0000, 16'h7FFF,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_LOAD, 9'd5, 32'h0000_0000, 32'h0000_0005, 32'h0080_0000, 32'h0000_0000, 16'h1000,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_LOAD, 9'd6, 32'h0000_0000, 32'h0100_0000, 32'hFF00_0000, 32'h0000_0000, 16'hF000,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_LOAD, 9'd7, 32'h0000_0000, 32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 16'h1000,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_LOAD, 9'd8, 32'h0000_0000, 32'h0100_0000, 32'h0100_0000, 32'h0000_0000, 16'h1000,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_LOAD, 9'd9, 32'hFFFF_FFFF, 32'h00C0_0000, 32'hFF40_0000, 32'h0001_8000, 16'h0C00,
         1'b0, 8'h00, 9'd0, 1'b0},
        {K_DATA, 9'h1FF, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 8'h02, 9'd0, 1'b0},
        {K_DATA, 9'h000, 32'h0000_0002, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 8'h02, 9'd1, 1'b0},
        {K_DATA, 9'h000, 32'hFFFF_FFFB, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 8'h00, 9'd2, 1'b0},
        {K_DATA, 9'h000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 8'h7F, 9'd3, 1'b0},
        {K_DATA, 9'h000, 32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 8'h80, 9'd4, 1'b0},
        {K_DATA, 9'h000, 32'h0080_0000, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 8'h01, 9'd5, 1'b0},
        {K_DATA, 9'h000, 32'h0000_0064, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 8'h64, 9'd6, 1'b0},
        {K_DATA, 9'h000, 32'hFFFF_FF7F, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 8'h80, 9'd7, 1'b0},
        {K_DATA, 9'h000, 32'hFFFF_FF80, 32'h0, 32'h0, 32'h0, 16'h0, 1'b1, 8'h80, 9'd8, 1'b0},
        {K_DATA, 9'h0AA, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF,
         1'b0, 8'h00, 9'd0, 1'b0}
    };

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic flag_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        n_errors++;
    endtask

    // Updates the predictor for one accepted item; returns 1 when the item yields a result.
    function automatic bit requant_step(input bnpr_pkg::t_in it, output bnpr_pkg::t_out res);
        logic [31:0]        bmag;
        logic [63:0]        prod_ld;
        logic [40:0]        ipl;
        logic [8:0]         ch;
        logic signed [63:0] x;
        logic [63:0]        mag;
        logic [15:0]        fm;
        logic [127:0]       wide;
        logic [32:0]        ip;
        logic [51:0]        frac;
        logic signed [7:0]  q;
        bit                 neg;
        bit                 end_ch;
        bit                 end_t;
        int unsigned        ppc;
        int unsigned        ciu;
        res = '0;
        if (it.kind == bnpr_pkg::KIND_LOAD) begin
            ch      = it.load_channel;
            bmag    = it.bn_scale_in[31] ? (~it.bn_scale_in + 32'd1) : it.bn_scale_in;
            prod_ld = {32'd0, it.conv_scale_in} * {32'd0, bmag};
            ipl     = {1'b0, prod_ld[63:24]};
            if (prod_ld[23:0] > 24'h80_0000 || (prod_ld[23:0] == 24'h80_0000 && ipl[0])) begin
                ipl = ipl + 41'd1;
            end
            if (it.bn_scale_in[31]) begin
                if (ipl > 41'h0_8000_0000) ipl = 41'h0_8000_0000;
                coef_scale[ch] = ~ipl[31:0] + 32'd1;
            end else begin
                if (ipl > 41'h0_7FFF_FFFF) ipl = 41'h0_7FFF_FFFF;
                coef_scale[ch] = ipl[31:0];
            end
            coef_offset[ch] = it.bn_offset_in;
            coef_slope[ch]  = it.slope_in;
            coef_loaded[ch] = 1'b1;
            return 1'b0;
        end

        ch  = 9'(chan_cnt);
        x   = $signed(it.acc) * $signed(coef_scale[ch]) + $signed(coef_offset[ch]) * 64'sd256;
        neg = x[63];
        mag = neg ? (~x + 64'd1) : x;
        if (!neg) begin
            fm = bnpr_pkg::SLOPE_ONE;
        end else if (coef_slope[ch][15]) begin
            // negative slope turns a negative x positive
            neg = 1'b0;
            fm  = ~coef_slope[ch] + 16'd1;
        end else begin
            fm = coef_slope[ch];
        end
        // 24 + 12 + 16 = 52 fraction bits
        wide = 128'(mag) * 128'(fm) * 128'(cfg_inv);
        if (wide[127:84] != '0) begin
            q = neg ? bnpr_pkg::Q_MIN : bnpr_pkg::Q_MAX;
        end else begin
            ip   = {1'b0, wide[83:52]};
            frac = wide[51:0];
            if (frac > 52'h8_0000_0000_0000 || (frac == 52'h8_0000_0000_0000 && ip[0])) begin
                ip = ip + 33'd1;
            end
            if (neg) q = (ip > 33'd128) ? bnpr_pkg::Q_MIN : (~ip[7:0] + 8'd1);
            else     q = (ip > 33'd127) ? bnpr_pkg::Q_MAX : ip[7:0];
        end

        ppc    = (cfg_ppc == 0) ? 1
                 : ((cfg_ppc > bnpr_pkg::PPC_MAX) ? bnpr_pkg::PPC_MAX : cfg_ppc);
        ciu    = (cfg_ciu == 0) ? 1 : ((cfg_ciu > MAX_CH) ? MAX_CH : cfg_ciu);
        end_ch = (pix_cnt + 1) >= ppc;
        end_t  = (int'(ch) + 1) >= ciu;

        res.quantized   = q;
        res.channel_out = ch;
        res.last        = end_ch && end_t;

        if (end_ch) begin
            pix_cnt  = 0;
            chan_cnt = end_t ? 0 : int'(ch) + 1;
        end else begin
            pix_cnt = (pix_cnt + 1) & 32'hFFFF;
        end
        return 1'b1;
    endfunction

    function automatic bnpr_pkg::t_in rand_load(input logic [8:0] ch);
        bnpr_pkg::t_in it;
        it.kind          = bnpr_pkg::KIND_LOAD;
        it.load_channel  = ch;
        it.acc           = $urandom;
        if ($urandom_range(0, 3) == 0) begin
            it.conv_scale_in = $urandom;
            it.bn_scale_in   = $urandom;
            it.bn_offset_in  = $urandom;
            it.slope_in      = 16'($urandom);
        end else begin
            // plausible coefficients: scales up to 2.0, offsets up to 64, slopes up to 2.0
            it.conv_scale_in = $urandom_range(32'h0004_0000, 32'h0200_0000);
            it.bn_scale_in   = $urandom_range(0, 32'h0400_0000) - 32'h0200_0000;
            it.bn_offset_in  = $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
            it.slope_in      = ($urandom_range(0, 7) == 0) ? 16'h0000
                                                           : 16'($urandom_range(0, 16384) - 8192);
        end
        return it;
    endfunction

    function automatic bnpr_pkg::t_in rand_data();
        bnpr_pkg::t_in it;
        it.kind          = bnpr_pkg::KIND_DATA;
        it.load_channel  = 9'($urandom);
        it.conv_scale_in = $urandom;
        it.bn_scale_in   = $urandom;
        it.bn_offset_in  = $urandom;
        it.slope_in      = 16'($urandom);
        if ($urandom_range(0, 3) == 0) it.acc = $urandom;
        else                           it.acc = $urandom_range(0, 512) - 256;
        return it;
    endfunction

    task automatic send_item(input bnpr_pkg::t_in it, input bit typed,
                             input bnpr_pkg::t_out want);
        bnpr_pkg::t_out res;
        int             gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        if (requant_step(it, res)) due_results.push_back(typed ? want : res);
        if ($urandom_range(0, 99) < idle_rate) begin
            gap = $urandom_range(1, 15);
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Sender stops until every outstanding result is back and any load has finished
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
        repeat (LOAD_SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [bnpr_pkg::CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            bnpr_pkg::CFG_INV_OUT_SCALE:      cfg_inv = val;
            bnpr_pkg::CFG_PIXELS_PER_CHANNEL: cfg_ppc = val[bnpr_pkg::PPC_W-1:0];
            bnpr_pkg::CFG_CHANNELS_IN_USE:    cfg_ciu = val[bnpr_pkg::CIU_W-1:0];
            default: ;
        endcase
    endtask

    task automatic run_phase(input logic [31:0] inv, input logic [31:0] ppc,
                             input logic [31:0] ciu, input int n_data, input int pct,
                             input bit hold);
        drain();
        write_reg(bnpr_pkg::CFG_INV_OUT_SCALE, inv);
        write_reg(bnpr_pkg::CFG_PIXELS_PER_CHANNEL, ppc);
        write_reg(bnpr_pkg::CFG_CHANNELS_IN_USE, ciu);
        @(negedge i_clk);
        i_cfg_we  <= 1'b0;
        idle_rate = pct;
        hold_req  = hold;
        repeat (n_data) begin
            // occasional reload of some channel while data is in flight
            if ($urandom_range(0, 9) == 0) send_item(rand_load(9'($urandom)), 1'b0, '0);
            // never let a data item read a channel that has no coefficients yet
            if (!coef_loaded[chan_cnt]) send_item(rand_load(9'(chan_cnt)), 1'b0, '0);
            send_item(rand_data(), 1'b0, '0);
            if ($urandom_range(0, 59) == 0) drain();
        end
    endtask

    initial begin : stimulus
        int i;
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        idle_rate   = 30;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (i = 0; i < $size(DIRECTED_STEPS); i++) begin
            send_item(DIRECTED_STEPS[i].item, DIRECTED_STEPS[i].typed, DIRECTED_STEPS[i].want);
        end

        // out-of-range register values, full 512-channel tensor through its last item and into the next
        run_phase(bnpr_pkg::INV_OUT_SCALE_RST, 32'd0, 32'd1023, 516 - int'(chan_cnt), 20, 1'b1);
        run_phase(32'd0, 32'd2, 32'd3, 20, 30, 1'b0);
        run_phase(32'hFFFF_FFFF, 32'd1, 32'd0, 20, 30, 1'b0);
        run_phase(32'd1, 32'd65536, 32'd2, 30, 10, 1'b0);
        run_phase($urandom, 32'h0001_FFFF, 32'd512, 20, 30, 1'b0);
        repeat (2) begin
            run_phase($urandom_range(32'h0000_4000, 32'h0002_0000), $urandom_range(1, 5),
                      $urandom_range(1, 8), 40, $urandom_range(0, 3) * 15, 1'b0);
        end
        run_phase(bnpr_pkg::INV_OUT_SCALE_RST, 32'd3, 32'd5, 40, 0, 1'b0);

        drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (n_errors == 0) begin
            $display("bn_prelu_int8_requantizer_top_tb: PASS");
        end else begin
            $display("bn_prelu_int8_requantizer_top_tb: FAIL");
        end
        $finish;
    end

    initial begin : result_sink
        int held;
        int burst;
        i_out_ready = 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                // long back-pressure so the block fills and stops taking items
                i_out_ready <= 1'b0;
                held = 0;
                while (held < HOLD_CYCLES) begin
                    @(negedge i_clk);
                    held++;
                end
                hold_req = 1'b0;
            end else if ($urandom_range(0, 99) < idle_rate) begin
                burst = $urandom_range(1, 15);
                i_out_ready <= 1'b0;
                repeat (burst - 1) @(negedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : result_check
        bnpr_pkg::t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                flag_error($sformatf("result with no item outstanding, ch %0d",
                                     o_out_data.channel_out));
            end else begin
                want = due_results.pop_front();
                if (o_out_data.quantized !== want.quantized) begin
                    flag_error($sformatf("quantized got %0d want %0d (ch %0d)",
                                         $signed(o_out_data.quantized),
                                         $signed(want.quantized), want.channel_out));
                end
                if (o_out_data.channel_out !== want.channel_out) begin
                    flag_error($sformatf("channel_out got %0d want %0d",
                                         o_out_data.channel_out, want.channel_out));
                end
                if (o_out_data.last !== want.last) begin
                    flag_error($sformatf("last got %0b want %0b (ch %0d)",
                                         o_out_data.last, want.last, want.channel_out));
                end
            end
        end
    end

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_cnt++;
        end
        $display("ERROR: timeout after %0d cycles", cycle_cnt);
        $display("bn_prelu_int8_requantizer_top_tb: FAIL");
        $finish;
    end

endmodule
